// ----- sv/lsmt_pkg.sv -----
// Shared types and constants for the LCD scanline and mode timing block.
// No dependencies; used by lsmt_step and lcd_scanline_mode_timing.
`default_nettype none

package lsmt_pkg;

	localparam logic [7:0] VBLANK_LINE = 8'd144;
	localparam logic [7:0] LAST_LINE   = 8'd153;

	localparam logic [9:0] PERIOD_RESET = 10'd114;
	localparam logic [9:0] MODE2_RESET  = 10'd94;
	localparam logic [9:0] MODE3_RESET  = 10'd51;

	localparam logic signed [15:0] COUNT_FLOOR = 16'sh8000;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	typedef enum logic [2:0] {
		REG_LCD_ON      = 3'd0,
		REG_BG_ENABLE   = 3'd1,
		REG_LINE_CMP    = 3'd2,
		REG_IRQ_ENABLES = 3'd3,
		REG_LINE_PERIOD = 3'd4,
		REG_MODE2_START = 3'd5,
		REG_MODE3_START = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic       lcd_on;
		logic       bg_enable;
		logic [7:0] line_compare;
		logic [3:0] stat_irq_enables;
		logic [9:0] line_period;
		logic [9:0] mode2_start;
		logic [9:0] mode3_start;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] countdown;
		logic [7:0]         line;
		lcd_mode_t          mode;
		logic               match;
	} state_t;

	typedef struct packed {
		logic [7:0] line_number;
		lcd_mode_t  lcd_mode;
		logic       coincidence;
		logic       stat_irq;
		logic       vblank_irq;
		logic       render_line;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/lsmt_step.sv -----
// One timing update: next scanline state and the result of one transaction.
// Purely combinational; uses lsmt_pkg types and constants.
`default_nettype none

module lsmt_step (
	input  var lsmt_pkg::cfg_t    cfg,
	input  var lsmt_pkg::state_t  cur,
	input  wire logic [7:0]       elapsed_cycles,
	output lsmt_pkg::state_t      nxt,
	output lsmt_pkg::result_t     res
);

	always_comb begin
		lsmt_pkg::lcd_mode_t mode;
		logic                en;
		logic                stat;
		logic                vbl;
		logic                rnd;
		logic                match;
		logic signed [15:0]  m2;
		logic signed [15:0]  m3;
		logic signed [16:0]  diff;
		logic signed [15:0]  sat;
		logic [7:0]          line_inc;
		logic [7:0]          line_nxt;
		logic signed [15:0]  cd_nxt;

		m2       = $signed({6'b0, cfg.mode2_start});
		m3       = $signed({6'b0, cfg.mode3_start});
		mode     = lsmt_pkg::MODE_HBLANK;
		en       = 1'b0;
		stat     = 1'b0;
		vbl      = 1'b0;
		rnd      = 1'b0;
		match    = cur.match;
		diff     = '0;
		sat      = '0;
		line_inc = cur.line + 8'd1;
		line_nxt = cur.line;
		cd_nxt   = cur.countdown;

		if (!cfg.lcd_on) begin
			mode     = lsmt_pkg::MODE_VBLANK;
			line_nxt = 8'd0;
			cd_nxt   = $signed({6'b0, cfg.line_period});
		end else begin
			if (cur.line >= lsmt_pkg::VBLANK_LINE) begin
				mode = lsmt_pkg::MODE_VBLANK;
				en   = cfg.stat_irq_enables[1];
			end else if ($signed(cur.countdown) >= m2) begin
				mode = lsmt_pkg::MODE_OAM;
				en   = cfg.stat_irq_enables[2];
			end else if ($signed(cur.countdown) >= m3) begin
				mode = lsmt_pkg::MODE_XFER;
				en   = 1'b0;
			end else begin
				mode = lsmt_pkg::MODE_HBLANK;
				en   = cfg.stat_irq_enables[0];
			end
			stat  = en && (mode != cur.mode);
			match = (cur.line == cfg.line_compare);
			if (match && cfg.stat_irq_enables[3]) begin
				stat = 1'b1;
			end

			diff = $signed({cur.countdown[15], cur.countdown}) - $signed({9'b0, elapsed_cycles});
			// only downward overflow is possible
			if (diff[16] != diff[15]) begin
				sat = lsmt_pkg::COUNT_FLOOR;
			end else begin
				sat = diff[15:0];
			end
			cd_nxt = sat;

			if (sat[15] || (sat == 16'sd0)) begin
				cd_nxt   = sat + $signed({6'b0, cfg.line_period});
				line_nxt = line_inc;
				if (line_inc == lsmt_pkg::VBLANK_LINE) begin
					vbl = 1'b1;
				end else if (line_inc > lsmt_pkg::LAST_LINE) begin
					line_nxt = 8'd0;
				end else if (line_inc < lsmt_pkg::VBLANK_LINE) begin
					rnd = cfg.bg_enable;
				end
			end
		end

		nxt.countdown   = cd_nxt;
		nxt.line        = line_nxt;
		nxt.mode        = mode;
		nxt.match       = match;
		res.line_number = line_nxt;
		res.lcd_mode    = mode;
		res.coincidence = match;
		res.stat_irq    = stat;
		res.vblank_irq  = vbl;
		res.render_line = rnd;
	end

endmodule

`default_nettype wire

// ----- sv/lcd_scanline_mode_timing.sv -----
// Top level of the LCD scanline and mode timing block: config registers,
// input stage, timing state and result register. Uses lsmt_pkg, lsmt_step.
//
// Channel   Handshake            Payload
// input     in_valid/in_ready    elapsed_cycles
// result    out_valid/out_ready  line_number, lcd_mode, coincidence,
//                                stat_irq, vblank_irq, render_line
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A result is registered through the input stage, then the result register;
// one transaction per cycle sustained while out_ready is high, set by the
// combinational state update in lsmt_step.
// Reset clears handshake state and loads register and timing reset values.
// A stalled result holds; the input stage keeps filling until both stages
// are occupied. cfg_ready is always high.
`default_nettype none

module lcd_scanline_mode_timing (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] elapsed_cycles,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      line_number,
	output logic [1:0]      lcd_mode,
	output logic            coincidence,
	output logic            stat_irq,
	output logic            vblank_irq,
	output logic            render_line,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [9:0] cfg_data
);

	lsmt_pkg::cfg_t    cfg_q;
	lsmt_pkg::state_t  state_q;
	lsmt_pkg::state_t  state_nxt;
	lsmt_pkg::result_t res_nxt;
	lsmt_pkg::result_t res_q;

	logic       valid_s1;
	logic [7:0] elapsed_s1;
	logic       out_valid_q;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lcd_on           <= 1'b0;
			cfg_q.bg_enable        <= 1'b0;
			cfg_q.line_compare     <= 8'd0;
			cfg_q.stat_irq_enables <= 4'd0;
			cfg_q.line_period      <= lsmt_pkg::PERIOD_RESET;
			cfg_q.mode2_start      <= lsmt_pkg::MODE2_RESET;
			cfg_q.mode3_start      <= lsmt_pkg::MODE3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (lsmt_pkg::cfg_reg_t'(cfg_index))
				lsmt_pkg::REG_LCD_ON:      cfg_q.lcd_on           <= cfg_data[0];
				lsmt_pkg::REG_BG_ENABLE:   cfg_q.bg_enable        <= cfg_data[0];
				lsmt_pkg::REG_LINE_CMP:    cfg_q.line_compare     <= cfg_data[7:0];
				lsmt_pkg::REG_IRQ_ENABLES: cfg_q.stat_irq_enables <= cfg_data[3:0];
				lsmt_pkg::REG_LINE_PERIOD: cfg_q.line_period      <= cfg_data;
				lsmt_pkg::REG_MODE2_START: cfg_q.mode2_start      <= cfg_data;
				lsmt_pkg::REG_MODE3_START: cfg_q.mode3_start      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			elapsed_s1 <= elapsed_cycles;
		end
	end

	lsmt_step u_step (
		.cfg            (cfg_q),
		.cur            (state_q),
		.elapsed_cycles (elapsed_s1),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.countdown <= $signed({6'b0, lsmt_pkg::PERIOD_RESET});
			state_q.line      <= 8'd0;
			state_q.mode      <= lsmt_pkg::MODE_HBLANK;
			state_q.match     <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = res_q.line_number;
	assign lcd_mode    = res_q.lcd_mode;
	assign coincidence = res_q.coincidence;
	assign stat_irq    = res_q.stat_irq;
	assign vblank_irq  = res_q.vblank_irq;
	assign render_line = res_q.render_line;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line <= lsmt_pkg::LAST_LINE)
		else $error("line counter beyond last line");

	a_count_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		$signed(state_q.countdown) <= 16'sd1023)
		else $error("countdown above maximum line period");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.vblank_irq |-> res_q.line_number == lsmt_pkg::VBLANK_LINE)
		else $error("vblank interrupt off line 144");

	a_render_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.render_line |->
			(res_q.line_number < lsmt_pkg::VBLANK_LINE) && (res_q.line_number != 8'd0))
		else $error("render request on a non-visible line");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(elapsed_s1))
		else $error("input stage lost a transaction");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for lcd_scanline_mode_timing: directed table, then random phases.
// Drives the input, result and config channels, with random idling on input and result.
// Depends on lsmt_pkg and the RTL in sv/.
`timescale 1ns / 100ps

module testbench;
	import lsmt_pkg::*;

	localparam logic [2:0] REG_UNKNOWN = 3'd7;
	localparam int N_DIR = 36;
	localparam int RANDOM_ITEMS = 1150;

	localparam result_t OFF_RESULT = '{8'd0, MODE_VBLANK, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam result_t FIRST_ON_RESULT = '{8'd0, MODE_OAM, 1'b1, 1'b1, 1'b0, 1'b0};

	typedef struct packed {
		logic       is_cfg;
		logic [2:0] idx;
		logic [9:0] data;
		logic       typed;
		result_t    res;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] elapsed_cycles;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] line_number;
	logic [1:0] lcd_mode;
	logic       coincidence;
	logic       stat_irq;
	logic       vblank_irq;
	logic       render_line;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	lcd_scanline_mode_timing u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.elapsed_cycles (elapsed_cycles),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_number    (line_number),
		.lcd_mode       (lcd_mode),
		.coincidence    (coincidence),
		.stat_irq       (stat_irq),
		.vblank_irq     (vblank_irq),
		.render_line    (render_line),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// timing mirror
	cfg_t      mirror_cfg;
	int        scan_cnt;
	logic [7:0] scan_line;
	lcd_mode_t scan_mode;
	logic      scan_match;

	result_t   expected_scan [$];
	int        mismatches;
	int        results_seen;
	bit        no_idle;
	bit        elapsed_all_max;
	bit        hold_done;
	dir_row_t  dir_rows [N_DIR];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#15ms;
		$display("[lcd_scanline_mode_timing] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	function automatic result_t predict_scanline(input logic [7:0] cyc);
		result_t   r;
		lcd_mode_t m;
		logic      en;
		r = '0;
		if (!mirror_cfg.lcd_on) begin
			scan_cnt  = int'(mirror_cfg.line_period);
			scan_line = 8'd0;
			scan_mode = MODE_VBLANK;
		end else begin
			if (scan_line >= VBLANK_LINE) begin
				m  = MODE_VBLANK;
				en = mirror_cfg.stat_irq_enables[1];
			end else if (scan_cnt >= int'(mirror_cfg.mode2_start)) begin
				m  = MODE_OAM;
				en = mirror_cfg.stat_irq_enables[2];
			end else if (scan_cnt >= int'(mirror_cfg.mode3_start)) begin
				m  = MODE_XFER;
				en = 1'b0;
			end else begin
				m  = MODE_HBLANK;
				en = mirror_cfg.stat_irq_enables[0];
			end
			r.stat_irq = en && (m != scan_mode);
			scan_mode  = m;
			scan_match = (scan_line == mirror_cfg.line_compare);
			if (scan_match && mirror_cfg.stat_irq_enables[3])
				r.stat_irq = 1'b1;
			scan_cnt = scan_cnt - int'(cyc);
			if (scan_cnt < int'(COUNT_FLOOR))
				scan_cnt = int'(COUNT_FLOOR);
			if (scan_cnt <= 0) begin
				scan_line = scan_line + 8'd1;
				scan_cnt  = scan_cnt + int'(mirror_cfg.line_period);
				if (scan_line == VBLANK_LINE)
					r.vblank_irq = 1'b1;
				else if (scan_line > LAST_LINE)
					scan_line = 8'd0;
				else if (scan_line < VBLANK_LINE)
					r.render_line = mirror_cfg.bg_enable;
			end
		end
		r.line_number = scan_line;
		r.lcd_mode    = scan_mode;
		r.coincidence = scan_match;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [7:0] pick_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (elapsed_all_max || r >= 93)
			return 8'hFF;
		if (r < 50)
			return 8'($urandom_range(0, 20));
		if (r < 85)
			return 8'($urandom_range(0, 255));
		return 8'h00;
	endfunction

	function automatic logic [9:0] with_noise(input logic [9:0] v, input logic [9:0] keep);
		return (10'($urandom()) & ~keep) | (v & keep);
	endfunction

	function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [9:0] data);
		return '{1'b1, idx, data, 1'b0, OFF_RESULT};
	endfunction

	function automatic dir_row_t item_row(input logic [7:0] cyc);
		return '{1'b0, 3'd0, {2'b00, cyc}, 1'b0, OFF_RESULT};
	endfunction

	function automatic dir_row_t typed_row(input logic [7:0] cyc, input result_t res);
		return '{1'b0, 3'd0, {2'b00, cyc}, 1'b1, res};
	endfunction

	// starts and returns at a rising edge; valid stays high after the transaction
	task automatic send_timing(input logic [7:0] cyc, input logic typed, input result_t res);
		int      gap;
		result_t pred;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pred = predict_scanline(cyc);
		expected_scan.push_back(typed ? res : pred);
		in_valid       <= 1'b1;
		elapsed_cycles <= cyc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
		in_valid <= 1'b0;
		while (expected_scan.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LCD_ON:      mirror_cfg.lcd_on           = data[0];
			REG_BG_ENABLE:   mirror_cfg.bg_enable        = data[0];
			REG_LINE_CMP:    mirror_cfg.line_compare     = data[7:0];
			REG_IRQ_ENABLES: mirror_cfg.stat_irq_enables = data[3:0];
			REG_LINE_PERIOD: mirror_cfg.line_period      = data;
			REG_MODE2_START: mirror_cfg.mode2_start      = data;
			REG_MODE3_START: mirror_cfg.mode3_start      = data;
			default: ;
		endcase
	endtask

	task automatic setup_phase(input int p);
		logic       on;
		logic       bg;
		logic [7:0] cmp;
		logic [3:0] en;
		logic [9:0] per;
		logic [9:0] m2;
		logic [9:0] m3;
		int         r;
		on  = ($urandom_range(0, 9) != 0);
		bg  = 1'($urandom());
		cmp = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 153)) : 8'($urandom());
		en  = 4'($urandom());
		r   = $urandom_range(0, 9);
		if (r == 0)
			per = 10'd0;
		else if (r == 1)
			per = 10'd1;
		else if (r == 2)
			per = 10'h3FF;
		else if (r < 6)
			per = 10'($urandom_range(1, 40));
		else
			per = 10'($urandom_range(60, 456));
		m2 = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, per)) : 10'($urandom());
		m3 = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, m2)) : 10'($urandom());
		no_idle         = ($urandom_range(0, 3) == 0);
		elapsed_all_max = ($urandom_range(0, 7) == 0);
		case (p)
			0: begin
				on = 1'b1; bg = 1'b1; per = PERIOD_RESET; m2 = MODE2_RESET; m3 = MODE3_RESET;
				no_idle = 1'b0; elapsed_all_max = 1'b0;
			end
			1: begin
				// drives the countdown down to its floor
				on = 1'b1; per = 10'd1; m2 = 10'd1; m3 = 10'd0; en = 4'hF;
				elapsed_all_max = 1'b1;
			end
			2: begin
				on = 1'b1; per = 10'd0; elapsed_all_max = 1'b0;
			end
			3: begin
				on = 1'b1; bg = 1'b0; cmp = 8'hFF; per = 10'h3FF; m2 = 10'h3FF; m3 = 10'd0;
				no_idle = 1'b1;
			end
			4: on = 1'b0;
			default: ;
		endcase
		write_reg(REG_LCD_ON, with_noise({9'd0, on}, 10'h001));
		write_reg(REG_BG_ENABLE, with_noise({9'd0, bg}, 10'h001));
		write_reg(REG_LINE_CMP, with_noise({2'd0, cmp}, 10'h0FF));
		write_reg(REG_IRQ_ENABLES, with_noise({6'd0, en}, 10'h00F));
		write_reg(REG_LINE_PERIOD, per);
		write_reg(REG_MODE2_START, m2);
		write_reg(REG_MODE3_START, m3);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNKNOWN, 10'($urandom()));
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_scan.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = expected_scan.pop_front();
				check_field("line_number", line_number, want.line_number);
				check_field("lcd_mode", {6'd0, lcd_mode}, {6'd0, want.lcd_mode});
				check_field("coincidence", {7'd0, coincidence}, {7'd0, want.coincidence});
				check_field("stat_irq", {7'd0, stat_irq}, {7'd0, want.stat_irq});
				check_field("vblank_irq", {7'd0, vblank_irq}, {7'd0, want.vblank_irq});
				check_field("render_line", {7'd0, render_line}, {7'd0, want.render_line});
			end
			results_seen++;
		end
	end

	// result receiver
	initial begin : receiver
		int stall;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= 200) begin
				// long back-pressure while input keeps coming
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (no_idle) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				stall = idle_len();
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int phase;
		int len;
		int random_items;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		elapsed_cycles <= 8'd0;
		cfg_valid      <= 1'b0;
		cfg_index      <= 3'd0;
		cfg_data       <= 10'd0;
		mismatches      = 0;
		results_seen    = 0;
		no_idle         = 1'b0;
		elapsed_all_max = 1'b0;
		hold_done       = 1'b0;
		mirror_cfg = '{1'b0, 1'b0, 8'd0, 4'd0, PERIOD_RESET, MODE2_RESET, MODE3_RESET};
		scan_cnt   = int'(PERIOD_RESET);
		scan_line  = 8'd0;
		scan_mode  = MODE_HBLANK;
		scan_match = 1'b0;

		dir_rows = '{
			typed_row(8'd0, OFF_RESULT),
			typed_row(8'd255, OFF_RESULT),
			cfg_row(REG_UNKNOWN, 10'h3FF),
			typed_row(8'd0, OFF_RESULT),
			cfg_row(REG_LINE_CMP, 10'h000),
			cfg_row(REG_IRQ_ENABLES, 10'h00F),
			cfg_row(REG_BG_ENABLE, 10'h001),
			cfg_row(REG_LCD_ON, 10'h001),
			typed_row(8'd0, FIRST_ON_RESULT),
			item_row(8'd60),
			item_row(8'd10),
			item_row(8'd44),
			item_row(8'd255),
			item_row(8'd0),
			cfg_row(REG_LINE_CMP, 10'h3FF),
			cfg_row(REG_IRQ_ENABLES, 10'h3F0),
			item_row(8'd255),
			item_row(8'd1),
			cfg_row(REG_LINE_PERIOD, 10'h000),
			item_row(8'd0),
			item_row(8'd0),
			item_row(8'd255),
			cfg_row(REG_LINE_PERIOD, 10'h3FF),
			cfg_row(REG_MODE2_START, 10'h3FF),
			cfg_row(REG_MODE3_START, 10'h000),
			cfg_row(REG_IRQ_ENABLES, 10'h00F),
			cfg_row(REG_LCD_ON, 10'h3FE),
			item_row(8'd7),
			cfg_row(REG_LCD_ON, 10'h001),
			item_row(8'd0),
			item_row(8'd128),
			item_row(8'd255),
			item_row(8'd255),
			cfg_row(REG_LINE_PERIOD, {2'b00, 8'(PERIOD_RESET)}),
			cfg_row(REG_MODE2_START, MODE2_RESET),
			cfg_row(REG_MODE3_START, MODE3_RESET)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send_timing(dir_rows[i].data[7:0], dir_rows[i].typed, dir_rows[i].res);
		end

		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			setup_phase(phase);
			if (phase == 0)
				len = 300;
			else if (phase == 1)
				len = 200;
			else
				len = $urandom_range(60, 150);
			for (int k = 0; k < len && random_items < RANDOM_ITEMS; k++) begin
				send_timing(pick_elapsed(), 1'b0, OFF_RESULT);
				random_items++;
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (expected_scan.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[lcd_scanline_mode_timing] OK");
		else
			$display("[lcd_scanline_mode_timing] ERROR");
		$finish;
	end

endmodule
